@@ hdl/tclpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tclpc_pkg
// Shared types and constants for the text command LED PWM controller.
// ----------------------------------------------------------------------------
package tclpc_pkg;

  // command line limits
  localparam int WORD_MAX = 8;
  localparam int ARG_MAX  = 16;
  localparam int ARG_KEPT = 6;

  localparam int WL_W   = $clog2(WORD_MAX + 1);
  localparam int AL_W   = $clog2(ARG_MAX + 1);
  localparam int NAME_W = 8 * WORD_MAX;

  // command names, first character in the low byte, zero padded
  localparam logic [NAME_W-1:0] NAME_RGB    = NAME_W'({"b", "g", "r"});
  localparam logic [NAME_W-1:0] NAME_RED    = NAME_W'({"d", "e", "r"});
  localparam logic [NAME_W-1:0] NAME_YELLOW = NAME_W'({"w", "o", "l", "l", "e", "y"});
  localparam logic [NAME_W-1:0] NAME_GREEN  = NAME_W'({"n", "e", "e", "r", "g"});

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LEVEL  = 2'd2;

  localparam logic [7:0] RED_LEVEL_RST    = 8'd10;
  localparam logic [7:0] YELLOW_LEVEL_RST = 8'd30;
  localparam logic [7:0] GREEN_LEVEL_RST  = 8'd10;

  typedef enum logic [1:0] {
    LIGHT_NONE   = 2'd0,
    LIGHT_RED    = 2'd1,
    LIGHT_YELLOW = 2'd2,
    LIGHT_GREEN  = 2'd3
  } light_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic       red_lamp;
    logic       yellow_lamp;
    logic       green_lamp;
    logic       rgb_red_out;
    logic       rgb_green_out;
    logic       rgb_blue_out;
    logic [1:0] lamp_select;
  } out_t;

  // parser state seen by the pwm side
  typedef struct packed {
    light_t          light;
    light_t          light_nxt;
    logic [2:0][7:0] rgb_levels;
  } cmd_status_t;

endpackage

@@ hdl/text_command_led_pwm_controller_top.sv @@
// ----------------------------------------------------------------------------
// text_command_led_pwm_controller_top
// Text command parser with PWM drive for three traffic lamps and an RGB LED.
// ----------------------------------------------------------------------------
// One word is accepted every clock cycle while the output side takes results: a
// word sits in the input register while the parser and the pwm compare update
// their state, and its result lands in the output register once that register
// is empty or being read. Input and output registers part the two channels; a
// stalled result only holds up input once the input register is also full.
// Level registers written on the configuration port take effect at the next
// tick word. Drive outputs change on tick words only; lamp_select follows
// the line just executed.
module text_command_led_pwm_controller_top
  import tclpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic        in_valid_r;
  in_t         in_data_r;
  logic        out_valid_r;
  out_t        out_data_r, out_data_nxt;
  logic        advance;
  logic        is_tick;
  logic [7:0]  red_level_r, yellow_level_r, green_level_r;
  logic [7:0]  pwm_phase_r, pwm_phase_nxt;
  logic [5:0]  lamp_lines_r, lamp_lines_nxt;
  logic [7:0]  r_level, y_level, g_level;
  cmd_status_t cmd;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign is_tick  = (in_data_r.operation == OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_level_r    <= RED_LEVEL_RST;
      yellow_level_r <= YELLOW_LEVEL_RST;
      green_level_r  <= GREEN_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RED_LEVEL:    red_level_r    <= cfg_wdata;
        CFG_YELLOW_LEVEL: yellow_level_r <= cfg_wdata;
        CFG_GREEN_LEVEL:  green_level_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tclpc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (advance && !is_tick),
    .byte_value (in_data_r.byte_value),
    .status     (cmd)
  );

  // unselected traffic lamps run at level zero
  assign r_level = (cmd.light == LIGHT_RED)    ? red_level_r    : 8'd0;
  assign y_level = (cmd.light == LIGHT_YELLOW) ? yellow_level_r : 8'd0;
  assign g_level = (cmd.light == LIGHT_GREEN)  ? green_level_r  : 8'd0;

  always_comb begin
    pwm_phase_nxt  = pwm_phase_r;
    lamp_lines_nxt = lamp_lines_r;
    if (advance && is_tick) begin
      pwm_phase_nxt  = pwm_phase_r + 8'd1;
      lamp_lines_nxt = {pwm_phase_nxt < cmd.rgb_levels[2],
                        pwm_phase_nxt < cmd.rgb_levels[1],
                        pwm_phase_nxt < cmd.rgb_levels[0],
                        pwm_phase_nxt < g_level,
                        pwm_phase_nxt < y_level,
                        pwm_phase_nxt < r_level};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_phase_r  <= '0;
      lamp_lines_r <= '0;
    end else begin
      pwm_phase_r  <= pwm_phase_nxt;
      lamp_lines_r <= lamp_lines_nxt;
    end
  end

  always_comb begin
    out_data_nxt.red_lamp      = lamp_lines_nxt[0];
    out_data_nxt.yellow_lamp   = lamp_lines_nxt[1];
    out_data_nxt.green_lamp    = lamp_lines_nxt[2];
    out_data_nxt.rgb_red_out   = lamp_lines_nxt[3];
    out_data_nxt.rgb_green_out = lamp_lines_nxt[4];
    out_data_nxt.rgb_blue_out  = lamp_lines_nxt[5];
    out_data_nxt.lamp_select   = cmd.light_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick |=> pwm_phase_r == $past(pwm_phase_r) + 8'd1)
    else $error("pwm phase did not advance by one on a tick");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && is_tick) |=> $stable(pwm_phase_r))
    else $error("pwm phase moved without a tick");

  a_select_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.lamp_select == cmd.light)
    else $error("lamp_select differs from the selected light");

  a_no_light_dark: assert property (@(posedge clk) disable iff (!rst_n)
    advance && is_tick && cmd.light == LIGHT_NONE |=>
      !out_data_r.red_lamp && !out_data_r.yellow_lamp && !out_data_r.green_lamp)
    else $error("traffic lamp lit with no light selected");
`endif

endmodule

@@ hdl/tclpc_parser.sv @@
// ----------------------------------------------------------------------------
// tclpc_parser
// Builds command word and argument from received bytes, executes on line end.
// ----------------------------------------------------------------------------
module tclpc_parser
  import tclpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic [7:0]  byte_value,
  output cmd_status_t status
);

  logic                           in_argument_r, in_argument_nxt;
  logic [WORD_MAX-1:0][7:0]       word_chars_r, word_chars_nxt;
  logic [WL_W-1:0]                word_length_r, word_length_nxt;
  logic [ARG_KEPT-1:0][7:0]       arg_chars_r, arg_chars_nxt;
  logic [AL_W-1:0]                arg_length_r, arg_length_nxt;
  light_t                         light_r, light_nxt;
  logic [2:0][7:0]                rgb_levels_r, rgb_levels_nxt;
  logic                           line_end;

  // compare stops at the first zero byte of the word
  function automatic logic word_is(input logic [WORD_MAX-1:0][7:0] w,
                                   input logic [WL_W-1:0] wl,
                                   input logic [NAME_W-1:0] name);
    logic       match;
    logic       done;
    logic [7:0] c;
    logic [7:0] n;
    match = 1'b1;
    done  = 1'b0;
    for (int i = 0; i < WORD_MAX; i++) begin
      c = (WL_W'(i) < wl) ? w[i] : 8'h00;
      n = name[8*i +: 8];
      if (!done) begin
        if (c != n) begin
          match = 1'b0;
          done  = 1'b1;
        end else if (c == 8'h00) begin
          done = 1'b1;
        end
      end
    end
    return match;
  endfunction

  // non-hex characters count as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] d);
    logic [3:0] v;
    v = 4'h0;
    if (d >= "0" && d <= "9") begin
      v = 4'(d - "0");
    end else if (d >= "a" && d <= "f") begin
      v = 4'(d - "a" + 8'd10);
    end else if (d >= "A" && d <= "F") begin
      v = 4'(d - "A" + 8'd10);
    end
    return v;
  endfunction

  assign line_end = (byte_value == CHAR_LF) || (byte_value == CHAR_CR);

  always_comb begin
    in_argument_nxt = in_argument_r;
    word_chars_nxt  = word_chars_r;
    word_length_nxt = word_length_r;
    arg_chars_nxt   = arg_chars_r;
    arg_length_nxt  = arg_length_r;
    light_nxt       = light_r;
    rgb_levels_nxt  = rgb_levels_r;
    if (byte_en) begin
      if (line_end) begin
        if (word_is(word_chars_r, word_length_r, NAME_RGB)) begin
          for (int k = 0; k < 3; k++) begin
            rgb_levels_nxt[k] = {hex_digit(arg_chars_r[2*k]), hex_digit(arg_chars_r[2*k+1])};
          end
        end else if (word_is(word_chars_r, word_length_r, NAME_RED)) begin
          light_nxt = LIGHT_RED;
        end else if (word_is(word_chars_r, word_length_r, NAME_YELLOW)) begin
          light_nxt = LIGHT_YELLOW;
        end else if (word_is(word_chars_r, word_length_r, NAME_GREEN)) begin
          light_nxt = LIGHT_GREEN;
        end
        in_argument_nxt = 1'b0;
        word_length_nxt = '0;
      end else if (!in_argument_r) begin
        if (byte_value == CHAR_SPACE) begin
          in_argument_nxt = 1'b1;
          arg_length_nxt  = '0;
        end else if (word_length_r < WL_W'(WORD_MAX)) begin
          for (int i = 0; i < WORD_MAX; i++) begin
            if (word_length_r == WL_W'(i)) begin
              word_chars_nxt[i] = byte_value;
            end
          end
          word_length_nxt = word_length_r + 1'b1;
        end
      end else if (arg_length_r < AL_W'(ARG_MAX)) begin
        // storing position k also clears position k+1
        for (int k = 0; k < ARG_KEPT; k++) begin
          if (arg_length_r == AL_W'(k)) begin
            arg_chars_nxt[k] = byte_value;
          end else if (arg_length_r + 1'b1 == AL_W'(k)) begin
            arg_chars_nxt[k] = 8'h00;
          end
        end
        arg_length_nxt = arg_length_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_argument_r <= 1'b0;
      word_chars_r  <= '0;
      word_length_r <= '0;
      arg_chars_r   <= '0;
      arg_length_r  <= '0;
      light_r       <= LIGHT_NONE;
      rgb_levels_r  <= '0;
    end else begin
      in_argument_r <= in_argument_nxt;
      word_chars_r  <= word_chars_nxt;
      word_length_r <= word_length_nxt;
      arg_chars_r   <= arg_chars_nxt;
      arg_length_r  <= arg_length_nxt;
      light_r       <= light_nxt;
      rgb_levels_r  <= rgb_levels_nxt;
    end
  end

  assign status.light      = light_r;
  assign status.light_nxt  = light_nxt;
  assign status.rgb_levels = rgb_levels_r;

endmodule

@@ verif/tb_text_command_led_pwm_controller_top.sv @@
// ----------------------------------------------------------------------------
// tb_text_command_led_pwm_controller_top
// Self-checking bench for the text command LED PWM controller. A directed
// table of bytes and ticks runs first, then random command lines, tick bursts
// and noise in phases with different lamp levels and handshake idling. A model
// of the parser and PWM predicts each result word the table does not type in.
// ----------------------------------------------------------------------------
module tb_text_command_led_pwm_controller_top;
  import tclpc_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_WORDS = 240;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;

  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   mismatch_count = 0;
  int   words_sent = 0;
  out_t lamp_result_q[$];

  // parser and pwm model state
  bit         arg_mode = 1'b0;
  logic [7:0] word_buf [WORD_MAX] = '{default: 8'h00};
  int         word_len = 0;
  logic [7:0] arg_buf [ARG_KEPT] = '{default: 8'h00};
  int         arg_len = 0;
  light_t     light_sel = LIGHT_NONE;
  logic [7:0] rgb_level [3] = '{default: 8'h00};
  logic [7:0] pwm_count = 8'h00;
  logic [5:0] drive_lines = 6'h00;
  logic [7:0] lamp_level [3] = '{RED_LEVEL_RST, YELLOW_LEVEL_RST, GREEN_LEVEL_RST};

  text_command_led_pwm_controller_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- model

  // names are packed first character in the low byte, zero padded
  function automatic bit word_equals(logic [NAME_W-1:0] name);
    logic [7:0] c;
    logic [7:0] n;
    for (int i = 0; i < WORD_MAX; i++) begin
      c = (i < word_len) ? word_buf[i] : 8'h00;
      n = name[8*i +: 8];
      if (c !== n) return 1'b0;
      if (c == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] d);
    if (d >= "0" && d <= "9") return 4'(d - "0");
    if (d >= "a" && d <= "f") return 4'(d - "a" + 10);
    if (d >= "A" && d <= "F") return 4'(d - "A" + 10);
    return 4'h0;
  endfunction

  function automatic void run_command();
    if (word_equals(NAME_RGB)) begin
      for (int k = 0; k < 3; k++)
        rgb_level[k] = {hex_nibble(arg_buf[2*k]), hex_nibble(arg_buf[2*k+1])};
    end else if (word_equals(NAME_RED)) begin
      light_sel = LIGHT_RED;
    end else if (word_equals(NAME_YELLOW)) begin
      light_sel = LIGHT_YELLOW;
    end else if (word_equals(NAME_GREEN)) begin
      light_sel = LIGHT_GREEN;
    end
  endfunction

  function automatic out_t predict_lamps(in_t w);
    out_t       r;
    logic [7:0] c;
    if (w.operation == OP_TICK) begin
      pwm_count = pwm_count + 8'd1;
      drive_lines[0] = pwm_count < ((light_sel == LIGHT_RED) ? lamp_level[CFG_RED_LEVEL] : 8'd0);
      drive_lines[1] = pwm_count <
                       ((light_sel == LIGHT_YELLOW) ? lamp_level[CFG_YELLOW_LEVEL] : 8'd0);
      drive_lines[2] = pwm_count <
                       ((light_sel == LIGHT_GREEN) ? lamp_level[CFG_GREEN_LEVEL] : 8'd0);
      for (int k = 0; k < 3; k++)
        drive_lines[3+k] = pwm_count < rgb_level[k];
    end else begin
      c = w.byte_value;
      if (c == CHAR_LF || c == CHAR_CR) begin
        run_command();
        arg_mode = 1'b0;
        word_len = 0;
      end else if (!arg_mode) begin
        if (c == CHAR_SPACE) begin
          arg_mode = 1'b1;
          arg_len = 0;
        end else if (word_len < WORD_MAX) begin
          word_buf[word_len] = c;
          word_len++;
        end
      end else if (arg_len < ARG_MAX) begin
        if (arg_len < ARG_KEPT) arg_buf[arg_len] = c;
        arg_len++;
        // storing a character zeroes the one after it
        if (arg_len < ARG_KEPT) arg_buf[arg_len] = 8'h00;
      end
    end
    r.red_lamp      = drive_lines[0];
    r.yellow_lamp   = drive_lines[1];
    r.green_lamp    = drive_lines[2];
    r.rgb_red_out   = drive_lines[3];
    r.rgb_green_out = drive_lines[4];
    r.rgb_blue_out  = drive_lines[5];
    r.lamp_select   = light_sel;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_word(in_t w, bit typed = 1'b0, out_t want = '0);
    out_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_lamps(w);
    lamp_result_q.push_back(typed ? want : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word({OP_BYTE, b});
  endtask

  task automatic send_tick();
    send_word({OP_TICK, 8'($urandom)});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (lamp_result_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_levels(logic [7:0] r, logic [7:0] y, logic [7:0] g);
    logic [7:0] vals [3];
    vals = '{r, y, g};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      lamp_level[i] = vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_command_line();
    string      cmds [5] = '{"rgb", "red", "yellow", "green", "blue"};
    string      hexset = "0123456789abcdefABCDEF";
    string      cmd;
    int         arg_n;
    logic [7:0] c;
    cmd = cmds[$urandom_range(4)];
    for (int i = 0; i < cmd.len(); i++) begin
      if ($urandom_range(7) == 0) send_tick();
      send_byte(cmd[i]);
    end
    // zero byte cuts the word short for the compare
    if ($urandom_range(9) == 0) begin
      send_byte(8'h00);
      repeat ($urandom_range(1, 3)) send_byte(8'("a" + $urandom_range(25)));
    end
    if ((cmd == "rgb") ? ($urandom_range(9) != 0) : ($urandom_range(3) == 0)) begin
      send_byte(CHAR_SPACE);
      arg_n = (cmd == "rgb" && $urandom_range(2) != 0) ? 6 : $urandom_range(20);
      repeat (arg_n) begin
        if ($urandom_range(7) == 0) send_tick();
        if ($urandom_range(9) != 0) begin
          c = hexset[$urandom_range(hexset.len() - 1)];
        end else begin
          c = 8'($urandom_range(255));
          if (c == CHAR_LF || c == CHAR_CR) c = CHAR_SPACE;
        end
        send_byte(c);
      end
    end
    send_byte($urandom_range(1) ? CHAR_LF : CHAR_CR);
  endtask

  task automatic send_random_stretch();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_command_line();
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 30)) send_tick();
    end else if (pick < 90) begin
      // unknown or overlong word
      repeat ($urandom_range(1, 12)) send_byte(8'("a" + $urandom_range(25)));
      send_byte($urandom_range(1) ? CHAR_LF : CHAR_CR);
    end else begin
      repeat ($urandom_range(1, 8)) send_word({1'($urandom), 8'($urandom)});
    end
  endtask

  function automatic stim_row_t mk_row(logic op, logic [7:0] b, bit typed, light_t sel);
    stim_row_t row;
    row.word = {op, b};
    row.typed = typed;
    row.want = '0;
    row.want.lamp_select = sel;
    return row;
  endfunction

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic void check_field(string fname, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t oldest;
    if (rst_n && out_valid && out_ready) begin
      if (lamp_result_q.size() == 0) begin
        $error("result word %h with nothing expected", out_data);
        mismatch_count++;
      end else begin
        oldest = lamp_result_q.pop_front();
        check_field("red_lamp", oldest.red_lamp, out_data.red_lamp);
        check_field("yellow_lamp", oldest.yellow_lamp, out_data.yellow_lamp);
        check_field("green_lamp", oldest.green_lamp, out_data.green_lamp);
        check_field("rgb_red_out", oldest.rgb_red_out, out_data.rgb_red_out);
        check_field("rgb_green_out", oldest.rgb_green_out, out_data.rgb_green_out);
        check_field("rgb_blue_out", oldest.rgb_blue_out, out_data.rgb_blue_out);
        check_field("lamp_select", oldest.lamp_select, out_data.lamp_select);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    stim_row_t dir_rows[$];
    int        phase_end;
    int        hold_at;
    int        pause_at;
    bit        hold_done;
    bit        pause_done;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // drives stay dark while no light is selected and the rgb levels are zero, "red" selects at the line end
    dir_rows = '{
      mk_row(OP_TICK, 8'hFF, 1'b1, LIGHT_NONE),
      mk_row(OP_BYTE, "r",      1'b1, LIGHT_NONE),
      mk_row(OP_BYTE, "e",      1'b1, LIGHT_NONE),
      mk_row(OP_BYTE, "d",      1'b1, LIGHT_NONE),
      mk_row(OP_BYTE, CHAR_LF,  1'b1, LIGHT_RED),
      mk_row(OP_TICK, 8'h00, 1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "r",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "g",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "b",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, CHAR_SPACE, 1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "F",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "0",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "a",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "1",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "z",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, "Z",      1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, CHAR_CR,  1'b0, LIGHT_NONE),
      mk_row(OP_TICK, 8'h00, 1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, 8'h00,    1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, 8'hFF,    1'b0, LIGHT_NONE),
      mk_row(OP_BYTE, CHAR_LF,  1'b0, LIGHT_NONE),
      mk_row(OP_TICK, 8'h5A, 1'b0, LIGHT_NONE)
    };
    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          set_levels(8'd0, 8'd0, 8'd0);
        end
        1: begin
          sender_idle_pct = 72;
          receiver_stall_pct = 0;
          set_levels(8'd255, 8'd255, 8'd255);
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 72;
          set_levels(8'($urandom), 8'($urandom), 8'($urandom));
        end
        3: begin
          sender_idle_pct = 31;
          receiver_stall_pct = 31;
          set_levels(8'd1, 8'd128, 8'd254);
        end
        default: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          set_levels(8'($urandom), 8'($urandom), 8'($urandom));
        end
      endcase
      phase_end = words_sent + PHASE_WORDS;
      hold_at = words_sent + 40;
      pause_at = words_sent + 140;
      hold_done = 1'b0;
      pause_done = 1'b0;
      while (words_sent < phase_end) begin
        if (p == 4 && !hold_done && words_sent >= hold_at) begin
          // receiver backs off while words keep coming
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if (p == 4 && !pause_done && words_sent >= pause_at) begin
          drain();
          pause_done = 1'b1;
        end
        send_random_stretch();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
